FILE: hw/rtl/mct_pkg.sv
package mct_pkg;

  // default sizes of the slot table
  localparam int unsigned SLOTS_DEF      = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF   = 16;

  // fixed port widths
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned SECONDS_W = 16;
  localparam int unsigned TAG_IN_W  = 16;
  localparam int unsigned TAG_OUT_W = 16;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // result kinds
  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // action codes on the input
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_CANCEL  = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  // classified commands handed from front to back
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADD     = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_RELEASE = 3'd3,
    OP_REJECT  = 3'd4
  } op_e;

  localparam int unsigned OP_W = $bits(op_e);

  // reply status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_FINISHED  = 3'd4
  } status_e;

  // slot phases
  typedef enum logic [1:0] {
    PH_RUN    = 2'd0,
    PH_CANCEL = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // one result beat
  typedef struct packed {
    logic                 kind;
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [TAG_OUT_W-1:0] tag;
    logic                 last;
  } res_t;

  // plain reply to a request
  function automatic res_t reply(input status_e st);
    res_t r;
    r.kind   = KIND_REPLY;
    r.status = st;
    r.slot   = '0;
    r.tag    = '0;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

FILE: hw/rtl/mct_front.sv
module mct_front #(
  parameter int unsigned SLOTS      = mct_pkg::SLOTS_DEF,
  parameter int unsigned COUNT_BITS = mct_pkg::COUNT_BITS_DEF,
  parameter int unsigned TAG_BITS   = mct_pkg::TAG_BITS_DEF,
  localparam int unsigned IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [1:0]                     action_i,
  input  logic [mct_pkg::SECONDS_W-1:0]  seconds_i,
  input  logic [mct_pkg::TAG_IN_W-1:0]   job_tag_i,
  input  logic [mct_pkg::SLOT_W-1:0]     slot_id_i,
  output mct_pkg::op_e                   op_o,
  output logic [COUNT_BITS-1:0]          count_o,
  output logic [TAG_BITS-1:0]            tag_o,
  output logic [IW-1:0]                  id_o
);

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic [31:0] sec_wide;
  logic [31:0] sec_sat;
  logic        id_oob;

  // saturate the count, trim the tag
  assign sec_wide = 32'(seconds_i);
  assign sec_sat  = (sec_wide > CountMax) ? CountMax : sec_wide;
  assign count_o  = COUNT_BITS'(sec_sat);
  assign tag_o    = TAG_BITS'(job_tag_i);

  // slot numbers past the table end are rejected here
  assign id_oob = ({1'b0, slot_id_i} >= (mct_pkg::SLOT_W + 1)'(SLOTS));
  assign id_o   = slot_id_i[IW-1:0];

  // classify the action
  always_comb begin
    unique case (mct_pkg::action_e'(action_i))
      mct_pkg::ACT_TICK:    op_o = mct_pkg::OP_TICK;
      mct_pkg::ACT_ADD:     op_o = (seconds_i == '0) ? mct_pkg::OP_REJECT : mct_pkg::OP_ADD;
      mct_pkg::ACT_CANCEL:  op_o = id_oob ? mct_pkg::OP_REJECT : mct_pkg::OP_CANCEL;
      mct_pkg::ACT_RELEASE: op_o = id_oob ? mct_pkg::OP_REJECT : mct_pkg::OP_RELEASE;
      default:              op_o = mct_pkg::OP_REJECT;
    endcase
  end

endmodule

FILE: hw/rtl/mct_fifo.sv
module mct_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = mct_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  data_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == CW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/mct_back.sv
module mct_back #(
  parameter int unsigned SLOTS      = mct_pkg::SLOTS_DEF,
  parameter int unsigned COUNT_BITS = mct_pkg::COUNT_BITS_DEF,
  parameter int unsigned TAG_BITS   = mct_pkg::TAG_BITS_DEF,
  localparam int unsigned IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  mct_pkg::op_e          cmd_op_i,
  input  logic [COUNT_BITS-1:0] cmd_count_i,
  input  logic [TAG_BITS-1:0]   cmd_tag_i,
  input  logic [IW-1:0]         cmd_id_i,
  output logic                  res_valid_o,
  output mct_pkg::res_t         res_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = 2 + COUNT_BITS + TAG_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_TICK   = 4'b0010,
    S_ADD    = 4'b0100,
    S_CANCEL = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // slot state memory: phase, count, tag
  logic [EW-1:0] mem_q [SLOTS];
  logic [EW-1:0] rd_data_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  mct_pkg::phase_e       rd_phase;
  logic [COUNT_BITS-1:0] rd_count, dec_count;
  logic [TAG_BITS-1:0]   rd_tag;

  logic [SLOTS-1:0]      used_q, used_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ev_vld_q, ev_vld_d;
  logic [IW-1:0]         ev_idx_q, ev_idx_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [IW-1:0]         pend_slot_q, pend_slot_d;
  logic [TAG_BITS-1:0]   pend_tag_q, pend_tag_d;
  logic [IW-1:0]         cur_id_q, cur_id_d;
  logic [COUNT_BITS-1:0] cur_count_q, cur_count_d;
  logic [TAG_BITS-1:0]   cur_tag_q, cur_tag_d;
  logic                  res_vld_q, res_vld_d;
  mct_pkg::res_t         res_q, res_d;
  logic                  scan_more;

  assign rd_phase  = mct_pkg::phase_e'(rd_data_q[EW-1 -: 2]);
  assign rd_count  = rd_data_q[TAG_BITS +: COUNT_BITS];
  assign rd_tag    = rd_data_q[TAG_BITS-1:0];
  assign dec_count = (rd_count != '0) ? rd_count - COUNT_BITS'(1) : rd_count;
  assign scan_more = (cnt_q < CW'(SLOTS));

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    pend_tag_d  = pend_tag_q;
    cur_id_d    = cur_id_q;
    cur_count_d = cur_count_q;
    cur_tag_d   = cur_tag_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[IW-1:0];
    wr_en       = 1'b0;
    wr_addr     = cur_id_q;
    wr_data     = rd_data_q;
    cmd_pop_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_op_i)
            mct_pkg::OP_TICK: begin
              cnt_d      = '0;
              pend_vld_d = 1'b0;
              state_d    = S_TICK;
            end
            mct_pkg::OP_ADD: begin
              cnt_d       = '0;
              cur_count_d = cmd_count_i;
              cur_tag_d   = cmd_tag_i;
              state_d     = S_ADD;
            end
            mct_pkg::OP_CANCEL: begin
              if (used_q[cmd_id_i]) begin
                rd_en    = 1'b1;
                rd_addr  = cmd_id_i;
                cur_id_d = cmd_id_i;
                state_d  = S_CANCEL;
              end else begin
                res_vld_d = 1'b1;
                res_d     = mct_pkg::reply(mct_pkg::ST_INVALID);
              end
            end
            mct_pkg::OP_RELEASE: begin
              res_vld_d = 1'b1;
              if (used_q[cmd_id_i]) begin
                used_d[cmd_id_i] = 1'b0;
                res_d            = mct_pkg::reply(mct_pkg::ST_OK);
              end else begin
                res_d = mct_pkg::reply(mct_pkg::ST_INVALID);
              end
            end
            default: begin
              res_vld_d = 1'b1;
              res_d     = mct_pkg::reply(mct_pkg::ST_INVALID);
            end
          endcase
        end
      end

      // one slot read per cycle, the slot read last cycle is updated
      S_TICK: begin
        if (scan_more) begin
          rd_en    = 1'b1;
          rd_addr  = cnt_q[IW-1:0];
          cnt_d    = cnt_q + 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = cnt_q[IW-1:0];
        end
        if (ev_vld_q && used_q[ev_idx_q] && (rd_phase == mct_pkg::PH_RUN)) begin
          wr_en   = 1'b1;
          wr_addr = ev_idx_q;
          if (dec_count == '0) begin
            wr_data = {mct_pkg::PH_DONE, dec_count, rd_tag};
            // an earlier expiry goes out now, it is not the last one
            if (pend_vld_q) begin
              res_vld_d   = 1'b1;
              res_d.kind  = mct_pkg::KIND_EXPIRY;
              res_d.status = mct_pkg::ST_OK;
              res_d.slot  = mct_pkg::SLOT_W'(pend_slot_q);
              res_d.tag   = mct_pkg::TAG_OUT_W'(pend_tag_q);
              res_d.last  = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = ev_idx_q;
            pend_tag_d  = rd_tag;
          end else begin
            wr_data = {mct_pkg::PH_RUN, dec_count, rd_tag};
          end
        end
        if (!scan_more && !ev_vld_q) begin
          if (pend_vld_q) begin
            res_vld_d    = 1'b1;
            res_d.kind   = mct_pkg::KIND_EXPIRY;
            res_d.status = mct_pkg::ST_OK;
            res_d.slot   = mct_pkg::SLOT_W'(pend_slot_q);
            res_d.tag    = mct_pkg::TAG_OUT_W'(pend_tag_q);
            res_d.last   = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      // walk the used bits for the lowest free slot
      S_ADD: begin
        if (!scan_more) begin
          res_vld_d = 1'b1;
          res_d     = mct_pkg::reply(mct_pkg::ST_FULL);
          state_d   = S_IDLE;
        end else if (!used_q[cnt_q[IW-1:0]]) begin
          wr_en                   = 1'b1;
          wr_addr                 = cnt_q[IW-1:0];
          wr_data                 = {mct_pkg::PH_RUN, cur_count_q, cur_tag_q};
          used_d[cnt_q[IW-1:0]]   = 1'b1;
          res_vld_d               = 1'b1;
          res_d                   = mct_pkg::reply(mct_pkg::ST_OK);
          res_d.slot              = mct_pkg::SLOT_W'(cnt_q[IW-1:0]);
          state_d                 = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // phase of the addressed slot is now in the read register
      S_CANCEL: begin
        res_vld_d = 1'b1;
        unique case (rd_phase)
          mct_pkg::PH_CANCEL: res_d = mct_pkg::reply(mct_pkg::ST_CANCELLED);
          mct_pkg::PH_DONE:   res_d = mct_pkg::reply(mct_pkg::ST_FINISHED);
          default: begin
            wr_en   = 1'b1;
            wr_addr = cur_id_q;
            wr_data = {mct_pkg::PH_CANCEL, rd_count, rd_tag};
            res_d   = mct_pkg::reply(mct_pkg::ST_OK);
          end
        endcase
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      cnt_q      <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      cnt_q      <= cnt_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ev_idx_q    <= ev_idx_d;
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
    cur_id_q    <= cur_id_d;
    cur_count_q <= cur_count_d;
    cur_tag_q   <= cur_tag_d;
    res_q       <= res_d;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/multi_slot_countdown_timer.sv
// a release or a rejected request replies from the idle state, a cancel after its slot read,
// an add after a free-slot walk (one used bit per cycle); a tick walks all slots for expiries
// one item in the back at a time; a tick holds it for a walk of every slot, bounded by
// the single read port of the slot memory that is walked one slot per cycle
// a two-entry command queue takes items while the back works; busy is high when it is full
// reset clears all slots to free and empties the queue; the receiver cannot stall results
module multi_slot_countdown_timer #(
  parameter int unsigned SLOTS      = mct_pkg::SLOTS_DEF,
  parameter int unsigned COUNT_BITS = mct_pkg::COUNT_BITS_DEF,
  parameter int unsigned TAG_BITS   = mct_pkg::TAG_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action_i,
  input  logic [mct_pkg::SECONDS_W-1:0]  seconds_i,
  input  logic [mct_pkg::TAG_IN_W-1:0]   job_tag_i,
  input  logic [mct_pkg::SLOT_W-1:0]     slot_id_i,
  output logic                           res_valid_o,
  output logic                           kind_o,
  output logic [2:0]                     status_o,
  output logic [mct_pkg::SLOT_W-1:0]     slot_o,
  output logic [mct_pkg::TAG_OUT_W-1:0]  tag_out_o,
  output logic                           last_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW = mct_pkg::OP_W + COUNT_BITS + TAG_BITS + IW;

  mct_pkg::op_e          f_op;
  logic [COUNT_BITS-1:0] f_count;
  logic [TAG_BITS-1:0]   f_tag;
  logic [IW-1:0]         f_id;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic                  q_full, q_empty, q_pop;
  mct_pkg::res_t         res;

  // front: classify the incoming item
  mct_front #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_front (
    .action_i  (action_i),
    .seconds_i (seconds_i),
    .job_tag_i (job_tag_i),
    .slot_id_i (slot_id_i),
    .op_o      (f_op),
    .count_o   (f_count),
    .tag_o     (f_tag),
    .id_o      (f_id)
  );

  assign q_wdata = {f_op, f_count, f_tag, f_id};
  assign busy    = q_full;

  // command queue
  mct_fifo #(
    .W     (QW),
    .DEPTH (mct_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !q_full),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: slot table and scans
  mct_back #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .cmd_op_i    (mct_pkg::op_e'(q_rdata[QW-1 -: mct_pkg::OP_W])),
    .cmd_count_i (q_rdata[TAG_BITS + IW +: COUNT_BITS]),
    .cmd_tag_i   (q_rdata[IW +: TAG_BITS]),
    .cmd_id_i    (q_rdata[IW-1:0]),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  assign kind_o    = res.kind;
  assign status_o  = res.status;
  assign slot_o    = res.slot;
  assign tag_out_o = res.tag;
  assign last_o    = res.last;

endmodule

FILE: hw/rtl/mct_checker.sv
module mct_checker #(
  parameter int unsigned SLOTS = mct_pkg::SLOTS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_o,
  input logic                          kind_o,
  input logic [2:0]                    status_o,
  input logic [mct_pkg::SLOT_W-1:0]    slot_o,
  input logic [mct_pkg::TAG_OUT_W-1:0] tag_out_o,
  input logic                          last_o
);

  // a reply always closes its item
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == mct_pkg::KIND_REPLY) |-> last_o)
    else $error("reply without last");

  // replies never carry a tag
  a_reply_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == mct_pkg::KIND_REPLY) |-> (tag_out_o == '0))
    else $error("reply with a tag");

  // a failed reply names no slot
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == mct_pkg::KIND_REPLY) && (status_o != mct_pkg::ST_OK)
    |-> (slot_o == '0))
    else $error("failed reply with a slot");

  // expiries are ok and lie inside the table
  a_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (kind_o == mct_pkg::KIND_EXPIRY)
    |-> (status_o == mct_pkg::ST_OK) && ({1'b0, slot_o} < (mct_pkg::SLOT_W + 1)'(SLOTS)))
    else $error("bad expiry beat");

endmodule

bind multi_slot_countdown_timer mct_checker #(.SLOTS(SLOTS)) u_mct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_o (res_valid_o),
  .kind_o      (kind_o),
  .status_o    (status_o),
  .slot_o      (slot_o),
  .tag_out_o   (tag_out_o),
  .last_o      (last_o)
);
